FILE: src/ssrk_pkg.sv
package ssrk_pkg;

    // default number of records one set can hold
    localparam int SSRK_CAPACITY = 64;

    // field widths of one record
    localparam int KEY_W    = 8;
    localparam int HANDLE_W = 16;

    // one stored record
    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic                sex;
        logic [HANDLE_W-1:0] handle;
    } t_rec;

    // controller states
    typedef enum logic [2:0] {
        S_LOAD,
        S_SCAN,
        S_SWAP_A,
        S_SWAP_B,
        S_EMIT_RD,
        S_EMIT_SHOW
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic sort_init;
        logic scan_issue;
        logic swap_a;
        logic swap_b;
        logic next_pass;
        logic emit_rd;
        logic emit_next;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic empty;
        logic scan_done;
        logic need_swap;
        logic last_pass;
        logic emit_last;
    } t_status;

endpackage

FILE: src/ssrk_dp.sv
module ssrk_dp
    import ssrk_pkg::*;
#(
    parameter int CAPACITY = SSRK_CAPACITY
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  t_rec                i_rec,
    output t_status             o_status,
    output t_rec                o_rec,
    output logic                o_last
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // record memory
    t_rec mem [CAPACITY];

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_pos;
    logic [CNT_W-1:0] r_scan;
    logic [CNT_W-1:0] r_k;
    logic [IDX_W-1:0] r_best;
    t_rec             r_best_rec;
    t_rec             r_pos_rec;
    t_rec             r_rd_data;
    logic [IDX_W-1:0] r_rd_idx;
    logic             r_rd_vld;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_rec             wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             not_full;

    // write port select: load, or one half of a swap
    always_comb begin
        not_full = (r_cnt < CNT_W'(CAPACITY));
        wr_en    = 1'b0;
        wr_addr  = r_cnt[IDX_W-1:0];
        wr_data  = i_rec;
        if (i_cmd.load && not_full) begin
            wr_en = 1'b1;
        end else if (i_cmd.swap_a) begin
            wr_en   = 1'b1;
            wr_addr = r_pos[IDX_W-1:0];
            wr_data = r_best_rec;
        end else if (i_cmd.swap_b) begin
            wr_en   = 1'b1;
            wr_addr = r_best;
            wr_data = r_pos_rec;
        end
    end

    // read port select: scan or emit
    always_comb begin
        rd_en   = i_cmd.scan_issue | i_cmd.emit_rd;
        rd_addr = i_cmd.scan_issue ? r_scan[IDX_W-1:0] : r_k[IDX_W-1:0];
    end

    // memory ports
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
        r_rd_idx <= r_scan[IDX_W-1:0];
    end

    // counters and read tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_pos    <= '0;
            r_scan   <= '0;
            r_k      <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan_issue;
            if (i_cmd.load && not_full) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (i_cmd.sort_init) begin
                r_pos  <= '0;
                r_scan <= '0;
                r_k    <= '0;
            end
            if (i_cmd.scan_issue) begin
                r_scan <= r_scan + CNT_W'(1);
            end
            if (i_cmd.next_pass) begin
                r_pos  <= r_pos + CNT_W'(1);
                r_scan <= r_pos + CNT_W'(1);
            end
            if (i_cmd.emit_next) begin
                r_k <= r_k + CNT_W'(1);
                if (o_status.emit_last) begin
                    r_cnt <= '0;
                end
            end
        end
    end

    // running minimum over the returned scan beats, first strict minimum wins
    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            if (r_rd_idx == r_pos[IDX_W-1:0]) begin
                r_best     <= r_rd_idx;
                r_best_rec <= r_rd_data;
                r_pos_rec  <= r_rd_data;
            end else if (r_rd_data.key < r_best_rec.key) begin
                r_best     <= r_rd_idx;
                r_best_rec <= r_rd_data;
            end
        end
    end

    // status to controller
    always_comb begin
        o_status.empty     = (r_cnt == '0);
        o_status.scan_done = (r_scan == r_cnt);
        o_status.need_swap = (r_best != r_pos[IDX_W-1:0]);
        o_status.last_pass = (({1'b0, r_pos} + (CNT_W+1)'(2)) >= {1'b0, r_cnt});
        o_status.emit_last = ((r_k + CNT_W'(1)) == r_cnt);
    end

    assign o_rec  = r_rd_data;
    assign o_last = o_status.emit_last;

endmodule

FILE: src/ssrk_ctrl.sv
module ssrk_ctrl
    import ssrk_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_last_in,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_in_ready,
    output logic    o_out_valid
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_last_in) begin
                        o_cmd.sort_init = 1'b1;
                        n_state = i_status.empty ? S_EMIT_RD : S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (i_status.scan_done) begin
                    n_state = S_SWAP_A;
                end else begin
                    o_cmd.scan_issue = 1'b1;
                end
            end
            S_SWAP_A: begin
                if (i_status.need_swap) begin
                    o_cmd.swap_a = 1'b1;
                    n_state = S_SWAP_B;
                end else begin
                    o_cmd.next_pass = 1'b1;
                    n_state = i_status.last_pass ? S_EMIT_RD : S_SCAN;
                end
            end
            S_SWAP_B: begin
                o_cmd.swap_b    = 1'b1;
                o_cmd.next_pass = 1'b1;
                n_state = i_status.last_pass ? S_EMIT_RD : S_SCAN;
            end
            S_EMIT_RD: begin
                o_cmd.emit_rd = 1'b1;
                n_state = S_EMIT_SHOW;
            end
            S_EMIT_SHOW: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.emit_next = 1'b1;
                    n_state = i_status.emit_last ? S_LOAD : S_EMIT_RD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

endmodule

FILE: src/selection_sort_records_by_key_top.sv
// channel | direction | handshake                  | fields
// input   | in        | i_in_valid / o_in_ready    | age, sex, record_handle, last_in
// output  | out       | o_out_valid / i_out_ready  | sorted_age, sorted_sex, sorted_handle, last_out
//
// loading accepts one record per cycle; a set of n records then sorts in passes
// pos = 0 .. n-2, each scanning the rest of the set through the single read
// port of the record memory and swapping only when the minimum lies elsewhere
// emission reads each record from memory, then shows it as one output beat
// synchronous active-low reset returns to loading with an empty set
// input is taken only while loading; output beats hold while i_out_ready is low
module selection_sort_records_by_key_top
    import ssrk_pkg::*;
#(
    parameter int CAPACITY = SSRK_CAPACITY
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [KEY_W-1:0]    i_age,
    input  logic                i_sex,
    input  logic [HANDLE_W-1:0] i_record_handle,
    input  logic                i_last_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [KEY_W-1:0]    o_sorted_age,
    output logic                o_sorted_sex,
    output logic [HANDLE_W-1:0] o_sorted_handle,
    output logic                o_last_out
);

    t_cmd    cmd;
    t_status status;
    t_rec    in_rec;
    t_rec    out_rec;

    // pack the input beat
    always_comb begin
        in_rec.key    = i_age;
        in_rec.sex    = i_sex;
        in_rec.handle = i_record_handle;
    end

    ssrk_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_in   (i_last_in),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid)
    );

    ssrk_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_rec    (in_rec),
        .o_status (status),
        .o_rec    (out_rec),
        .o_last   (o_last_out)
    );

    // unpack the output beat
    assign o_sorted_age    = out_rec.key;
    assign o_sorted_sex    = out_rec.sex;
    assign o_sorted_handle = out_rec.handle;

endmodule

FILE: src/ssrk_checker.sv
module ssrk_checker
    import ssrk_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                o_in_ready,
    input  logic                i_last_in,
    input  logic                o_out_valid,
    input  logic                i_out_ready,
    input  logic [KEY_W-1:0]    o_sorted_age,
    input  logic                o_sorted_sex,
    input  logic [HANDLE_W-1:0] o_sorted_handle,
    input  logic                o_last_out
);

    // loading and emitting never overlap
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while output valid");

    // closing beat stops loading
    a_close_stops_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_last_in) |=> !o_in_ready)
        else $error("input still ready after closing beat");

    // final output beat ends emission
    a_last_ends_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last_out) |=> !o_out_valid)
        else $error("output valid after final beat");

    // stalled output holds valid
    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("output valid dropped while stalled");

    // stalled output holds payload
    a_out_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            ($stable(o_sorted_age) && $stable(o_sorted_sex) &&
             $stable(o_sorted_handle) && $stable(o_last_out)))
        else $error("output payload changed while stalled");

endmodule

bind selection_sort_records_by_key_top ssrk_checker u_ssrk_checker (.*);

FILE: verif/selection_sort_records_by_key_top_tb.sv
`timescale 1ns / 1ps

module selection_sort_records_by_key_top_tb;
    import ssrk_pkg::*;

    localparam int CAPACITY     = SSRK_CAPACITY;
    localparam int IDLE_LIMIT   = 20000;
    localparam int RANDOM_ITEMS = 25;
    localparam int DRAIN_CYCLES = 200;

    // one output beat as predicted
    typedef struct packed {
        t_rec rec;
        logic last;
    } t_sorted_beat;

    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                i_in_valid      = 1'b0;
    logic                o_in_ready;
    logic [KEY_W-1:0]    i_age           = '0;
    logic                i_sex           = 1'b0;
    logic [HANDLE_W-1:0] i_record_handle = '0;
    logic                i_last_in       = 1'b0;
    logic                o_out_valid;
    logic                i_out_ready     = 1'b0;
    logic [KEY_W-1:0]    o_sorted_age;
    logic                o_sorted_sex;
    logic [HANDLE_W-1:0] o_sorted_handle;
    logic                o_last_out;

    // records of the set being loaded, and sorted beats still owed by the block
    t_rec         open_set[$];
    t_sorted_beat sorted_beats_due[$];

    int error_count = 0;
    int idle_cycles = 0;
    int stall_left  = 0;
    bit send_gaps   = 1'b1;
    bit recv_stalls = 1'b1;

    selection_sort_records_by_key_top #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_age          (i_age),
        .i_sex          (i_sex),
        .i_record_handle(i_record_handle),
        .i_last_in      (i_last_in),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_sorted_age   (o_sorted_age),
        .o_sorted_sex   (o_sorted_sex),
        .o_sorted_handle(o_sorted_handle),
        .o_last_out     (o_last_out)
    );

    always #10 i_clk = ~i_clk;

    // store a record; on the closing record sort the set and queue its beats
    function automatic void load_record(t_rec rec, logic last);
        int           best;
        t_rec         tmp;
        t_sorted_beat beat;
        if (open_set.size() < CAPACITY)
            open_set.push_back(rec);
        if (last) begin
            // first strict minimum of the rest, swapped in only when elsewhere
            for (int pos = 0; pos < open_set.size(); pos++) begin
                best = pos;
                for (int scan = pos + 1; scan < open_set.size(); scan++) begin
                    if (open_set[scan].key < open_set[best].key)
                        best = scan;
                end
                if (best != pos) begin
                    tmp            = open_set[pos];
                    open_set[pos]  = open_set[best];
                    open_set[best] = tmp;
                end
            end
            foreach (open_set[k]) begin
                beat.rec  = open_set[k];
                beat.last = (k == open_set.size() - 1);
                sorted_beats_due.push_back(beat);
            end
            open_set.delete();
        end
    endfunction

    // drive one input beat and wait for it to be taken
    task automatic send_record(input logic [KEY_W-1:0] age, input logic sex,
                               input logic [HANDLE_W-1:0] handle, input logic last);
        t_rec rec;
        rec.key    = age;
        rec.sex    = sex;
        rec.handle = handle;
        if (send_gaps && $urandom_range(0, 2) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_age           <= age;
        i_sex           <= sex;
        i_record_handle <= handle;
        i_last_in       <= last;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        load_record(rec, last);
    endtask

    task automatic hold_input();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_sets_emitted();
        hold_input();
        while (sorted_beats_due.size() != 0) @(posedge i_clk);
    endtask

    // one set of random records, narrow keys give many ties
    task automatic send_random_set(input int count, input bit narrow_keys);
        logic [KEY_W-1:0] age;
        for (int k = 0; k < count; k++) begin
            age = narrow_keys ? KEY_W'($urandom_range(0, 3)) : KEY_W'($urandom_range(0, 255));
            send_record(age, 1'($urandom_range(0, 1)), HANDLE_W'($urandom_range(0, 65535)),
                        k == count - 1);
        end
    endtask

    // sets of one record, all-ones then all-zeros fields
    task automatic test_single_record();
        send_record(8'hFF, 1'b1, 16'hFFFF, 1'b1);
        send_record(8'h00, 1'b0, 16'h0000, 1'b1);
    endtask

    task automatic test_field_extremes();
        send_record(8'hFF, 1'b1, 16'h0000, 1'b0);
        send_record(8'h00, 1'b0, 16'hFFFF, 1'b0);
        send_record(8'h80, 1'b1, 16'hAAAA, 1'b0);
        send_record(8'h7F, 1'b0, 16'h5555, 1'b1);
    endtask

    // ties: swap order decides where equal keys land; sender waits for the block first
    task automatic test_equal_keys();
        logic [KEY_W-1:0] keys[6] = '{8'd5, 8'd5, 8'd3, 8'd5, 8'd3, 8'd1};
        wait_sets_emitted();
        foreach (keys[k])
            send_record(keys[k], 1'(k), HANDLE_W'(16'h1000 + k), k == 5);
    endtask

    task automatic test_ordered_sets();
        for (int k = 0; k < 4; k++)
            send_record(KEY_W'(10 * (k + 1)), 1'(k), HANDLE_W'(16'h2000 + k), k == 3);
        for (int k = 0; k < 4; k++)
            send_record(KEY_W'(200 - 50 * k), 1'(k), HANDLE_W'(16'h3000 + k), k == 3);
    endtask

    // full store drops further records; a dropped closing record still closes the set
    task automatic test_store_full();
        for (int k = 0; k < CAPACITY + 2; k++)
            send_record(KEY_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                        HANDLE_W'(k), k == CAPACITY + 1);
        send_random_set(2, 1'b0);
    endtask

    task automatic test_random_sets();
        int sent;
        int count;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            send_gaps   = ($urandom_range(0, 3) != 0);
            recv_stalls = ($urandom_range(0, 3) != 0);
            count = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            send_random_set(count, $urandom_range(0, 2) == 0);
            sent += count;
            if ($urandom_range(0, 5) == 0)
                wait_sets_emitted();
        end
    endtask

    // last part of the run: no idling on either side
    task automatic test_steady_stream();
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
        for (int s = 0; s < 3; s++)
            send_random_set($urandom_range(1, 8), s == 1);
    endtask

    // receiver ready with random stall bursts
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else if (recv_stalls && $urandom_range(0, 5) == 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= $urandom_range(0, 3);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // compare each output beat with the oldest prediction
    always @(posedge i_clk) begin : check_beat
        t_sorted_beat want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (sorted_beats_due.size() == 0) begin
                $error("output beat with none expected: age %0d handle %h",
                       o_sorted_age, o_sorted_handle);
                error_count++;
            end else begin
                want = sorted_beats_due.pop_front();
                if (o_sorted_age !== want.rec.key) begin
                    $error("sorted_age: expected %0d, got %0d", want.rec.key, o_sorted_age);
                    error_count++;
                end
                if (o_sorted_sex !== want.rec.sex) begin
                    $error("sorted_sex: expected %0d, got %0d", want.rec.sex, o_sorted_sex);
                    error_count++;
                end
                if (o_sorted_handle !== want.rec.handle) begin
                    $error("sorted_handle: expected %h, got %h",
                           want.rec.handle, o_sorted_handle);
                    error_count++;
                end
                if (o_last_out !== want.last) begin
                    $error("last_out: expected %0d, got %0d", want.last, o_last_out);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready === 1'b1) || (o_out_valid === 1'b1 && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("selection_sort_records_by_key_top_tb: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_record();
        test_field_extremes();
        test_equal_keys();
        test_ordered_sets();
        test_store_full();
        test_random_sets();
        test_steady_stream();

        wait_sets_emitted();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && sorted_beats_due.size() == 0)
            $display("selection_sort_records_by_key_top_tb: done, clean");
        else
            $display("selection_sort_records_by_key_top_tb: done, errors");
        $finish;
    end

endmodule

FILE: selection_sort_records_by_key_top.f
src/ssrk_pkg.sv
src/ssrk_dp.sv
src/ssrk_ctrl.sv
src/selection_sort_records_by_key_top.sv
src/ssrk_checker.sv
verif/selection_sort_records_by_key_top_tb.sv
